>>> design/abgs_pkg.sv
package abgs_pkg;

  localparam int PIXEL_INDEX_BITS = 17;
  localparam int FRAME_COUNT_BITS = 12;

  localparam int CH_W    = 8;
  localparam int NUM_CH  = 3;
  localparam int SCALE_W = 4;
  localparam int SUM_W   = FRAME_COUNT_BITS + CH_W;
  localparam int DC_W    = SUM_W + 1;
  localparam int PROD_W  = DC_W + SCALE_W;
  localparam int CMP_W   = PROD_W + 1;
  localparam int SUMS_W  = 2 * NUM_CH * SUM_W;
  localparam int PREV_W  = NUM_CH * CH_W;
  localparam int DEPTH   = 1 << PIXEL_INDEX_BITS;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = SCALE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_HI_SCALE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_SCALE = CFG_IDX_W'(1);

  localparam logic [SCALE_W-1:0] HI_SCALE_RST  = SCALE_W'(7);
  localparam logic [SCALE_W-1:0] LOW_SCALE_RST = SCALE_W'(6);

  localparam logic OP_LEARN    = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  localparam logic [FRAME_COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    CMD_PREV,
    CMD_ACCUM,
    CMD_CLASSIFY
  } cmd_kind_t;

  typedef logic [CH_W-1:0] chan_t;
  typedef chan_t [NUM_CH-1:0] pix_t;

  typedef struct packed {
    cmd_kind_t                     kind;
    logic [PIXEL_INDEX_BITS-1:0]   addr;
    pix_t                          pix;
    logic                          fe;
    logic [FRAME_COUNT_BITS-1:0]   cnt;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> design/abgs_if.sv
interface abgs_in_if import abgs_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [PIXEL_INDEX_BITS-1:0] pixel_index;
  logic [CH_W-1:0]             chan_a;
  logic [CH_W-1:0]             chan_b;
  logic [CH_W-1:0]             chan_c;
  logic                        frame_end;

  modport source (
    output valid, opcode, pixel_index, chan_a, chan_b, chan_c, frame_end,
    input  ready
  );
  modport sink (
    input  valid, opcode, pixel_index, chan_a, chan_b, chan_c, frame_end,
    output ready
  );
endinterface

interface abgs_out_if import abgs_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [PIXEL_INDEX_BITS-1:0] out_index;
  logic                        foreground;
  logic                        within_a;
  logic                        within_b;
  logic                        within_c;
  logic                        out_frame_end;

  modport source (
    output valid, out_index, foreground, within_a, within_b, within_c, out_frame_end,
    input  ready
  );
  modport sink (
    input  valid, out_index, foreground, within_a, within_b, within_c, out_frame_end,
    output ready
  );
endinterface

>>> design/abgs_ram.sv
module abgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

>>> design/abgs_front.sv
module abgs_front import abgs_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  abgs_in_if.sink      in_ch,
  input  logic         clr_busy,
  input  q_stat_t      q_stat,
  output logic         q_push,
  output cmd_t         q_cmd
);

  logic                        awaiting_r, awaiting_nxt;
  logic [FRAME_COUNT_BITS-1:0] fcount_r, fcount_nxt;
  logic                        acc;

  assign in_ch.ready = !q_stat.full && !clr_busy;
  assign acc         = in_ch.valid && in_ch.ready;

  // decode the item against the frame state seen at its transfer
  always_comb begin
    awaiting_nxt = awaiting_r;
    fcount_nxt   = fcount_r;
    q_push       = 1'b0;
    q_cmd.kind   = CMD_CLASSIFY;
    q_cmd.addr   = in_ch.pixel_index;
    q_cmd.pix    = {in_ch.chan_c, in_ch.chan_b, in_ch.chan_a};
    q_cmd.fe     = in_ch.frame_end;
    q_cmd.cnt    = fcount_r;
    unique case (in_ch.opcode)
      OP_LEARN: begin
        if (awaiting_r) begin
          q_cmd.kind = CMD_PREV;
          q_push     = acc;
          if (acc && in_ch.frame_end) begin
            awaiting_nxt = 1'b0;
          end
        end else if (fcount_r != COUNT_MAX) begin
          q_cmd.kind = CMD_ACCUM;
          q_push     = acc;
          if (acc && in_ch.frame_end) begin
            fcount_nxt = fcount_r + 1'b1;
          end
        end
        // count full: learn item dropped here
      end
      OP_CLASSIFY: begin
        q_push = acc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r <= 1'b1;
      fcount_r   <= '0;
    end else begin
      awaiting_r <= awaiting_nxt;
      fcount_r   <= fcount_nxt;
    end
  end

endmodule

>>> design/abgs_fifo.sv
module abgs_fifo import abgs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    din,
  input  logic    pop,
  output cmd_t    dout,
  output q_stat_t stat
);

  cmd_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign stat.full  = cnt_r == (FIFO_AW+1)'(FIFO_DEPTH);
  assign stat.empty = cnt_r == '0;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign dout       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

>>> design/abgs_back.sv
module abgs_back import abgs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [SCALE_W-1:0] hi_scale,
  input  logic [SCALE_W-1:0] low_scale,
  input  cmd_t               q_head,
  input  q_stat_t            q_stat,
  output logic               q_pop,
  output logic               clr_busy,
  abgs_out_if.source         out_ch
);

  typedef struct packed {
    logic [NUM_CH-1:0][SUM_W-1:0] csum;
    logic [NUM_CH-1:0][SUM_W-1:0] dsum;
  } sums_t;

  typedef struct packed {
    logic [SUM_W-1:0]  s;
    logic [SUM_W-1:0]  xn;
    logic [PROD_W-1:0] lm;
    logic [PROD_W-1:0] hm;
  } chk_t;

  logic                        en;

  // init clear of the sum store
  logic                        clr_busy_r;
  logic [PIXEL_INDEX_BITS-1:0] clr_cnt_r;

  // RAM ports
  logic                        sum_we, prev_we, sram_we;
  logic [PIXEL_INDEX_BITS-1:0] sram_waddr;
  logic [SUMS_W-1:0]           sram_wdata, sums_rd;
  logic [PREV_W-1:0]           prev_rd;

  // stage B: RAM data back, update / multiply
  logic                        b_vld_r;
  cmd_t                        b_cmd_r;
  logic                        byp_sum_r, byp_sum_nxt;
  logic                        byp_prev_r, byp_prev_nxt;
  sums_t                       byp_sums_r;
  pix_t                        byp_pix_r;
  sums_t                       sums_cur, sums_new;
  pix_t                        pix_prev;
  logic                        is_cls;
  chk_t                        chk_nxt [NUM_CH];

  // stage C: range compare
  logic                        c_vld_r;
  logic [PIXEL_INDEX_BITS-1:0] c_addr_r;
  logic                        c_fe_r;
  chk_t                        c_chk_r [NUM_CH];
  logic [NUM_CH-1:0]           in_rng;

  // output register
  logic                        out_vld_r;
  logic [PIXEL_INDEX_BITS-1:0] out_idx_r;
  logic                        out_fg_r;
  logic [NUM_CH-1:0]           out_w_r;
  logic                        out_fe_r;

  assign en       = !out_vld_r || out_ch.ready;
  assign q_pop    = en && !clr_busy_r && !q_stat.empty;
  assign clr_busy = clr_busy_r;

  assign sum_we  = en && b_vld_r && (b_cmd_r.kind == CMD_ACCUM);
  assign prev_we = en && b_vld_r &&
                   (b_cmd_r.kind == CMD_ACCUM || b_cmd_r.kind == CMD_PREV);
  assign is_cls  = b_vld_r && (b_cmd_r.kind == CMD_CLASSIFY);

  assign sram_we    = clr_busy_r || sum_we;
  assign sram_waddr = clr_busy_r ? clr_cnt_r : b_cmd_r.addr;
  assign sram_wdata = clr_busy_r ? '0 : sums_new;

  abgs_ram #(
    .WIDTH (SUMS_W),
    .DEPTH (DEPTH)
  ) u_sum_ram (
    .clk   (clk),
    .we    (sram_we),
    .waddr (sram_waddr),
    .wdata (sram_wdata),
    .re    (en),
    .raddr (q_head.addr),
    .rdata (sums_rd)
  );

  abgs_ram #(
    .WIDTH (PREV_W),
    .DEPTH (DEPTH)
  ) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (b_cmd_r.addr),
    .wdata (b_cmd_r.pix),
    .re    (en),
    .raddr (q_head.addr),
    .rdata (prev_rd)
  );

  // read data is stale when the item just ahead wrote the same pixel
  assign sums_cur = byp_sum_r ? byp_sums_r : sums_t'(sums_rd);
  assign pix_prev = byp_prev_r ? byp_pix_r : pix_t'(prev_rd);

  always_comb begin
    logic [CH_W-1:0]             ad;
    logic                        cnt_zero;
    logic [FRAME_COUNT_BITS-1:0] cnt_eff;
    logic [SUM_W-1:0]            s_eff;
    logic [SUM_W-1:0]            d_eff;
    logic [DC_W-1:0]             dc;
    sums_new = sums_cur;
    cnt_zero = b_cmd_r.cnt == '0;
    cnt_eff  = cnt_zero ? FRAME_COUNT_BITS'(1) : b_cmd_r.cnt;
    for (int k = 0; k < NUM_CH; k++) begin
      ad = (b_cmd_r.pix[k] > pix_prev[k]) ? b_cmd_r.pix[k] - pix_prev[k]
                                          : pix_prev[k] - b_cmd_r.pix[k];
      sums_new.csum[k] = sums_cur.csum[k] + SUM_W'(b_cmd_r.pix[k]);
      sums_new.dsum[k] = sums_cur.dsum[k] + SUM_W'(ad);

      s_eff         = cnt_zero ? '0 : sums_cur.csum[k];
      d_eff         = cnt_zero ? '0 : sums_cur.dsum[k];
      dc            = DC_W'(d_eff) + DC_W'(cnt_eff);
      chk_nxt[k].s  = s_eff;
      chk_nxt[k].xn = SUM_W'(b_cmd_r.pix[k]) * SUM_W'(cnt_eff);
      chk_nxt[k].lm = PROD_W'(low_scale) * PROD_W'(dc);
      chk_nxt[k].hm = PROD_W'(hi_scale) * PROD_W'(dc);
    end
  end

  assign byp_sum_nxt  = q_pop && sum_we && (q_head.addr == b_cmd_r.addr);
  assign byp_prev_nxt = q_pop && prev_we && (q_head.addr == b_cmd_r.addr);

  // s - lm <= xn < s + hm, kept unsigned
  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      in_rng[k] = (CMP_W'(c_chk_r[k].s) <= CMP_W'(c_chk_r[k].xn) + CMP_W'(c_chk_r[k].lm)) &&
                  (CMP_W'(c_chk_r[k].xn) < CMP_W'(c_chk_r[k].s) + CMP_W'(c_chk_r[k].hm));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
      b_vld_r    <= 1'b0;
      byp_sum_r  <= 1'b0;
      byp_prev_r <= 1'b0;
      c_vld_r    <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (en) begin
        b_vld_r    <= q_pop;
        byp_sum_r  <= byp_sum_nxt;
        byp_prev_r <= byp_prev_nxt;
        c_vld_r    <= is_cls;
        out_vld_r  <= c_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_cmd_r    <= q_head;
      byp_sums_r <= sums_new;
      byp_pix_r  <= b_cmd_r.pix;
      c_addr_r   <= b_cmd_r.addr;
      c_fe_r     <= b_cmd_r.fe;
      c_chk_r    <= chk_nxt;
      out_idx_r  <= c_addr_r;
      out_fg_r   <= ~|in_rng;
      out_w_r    <= in_rng;
      out_fe_r   <= c_fe_r;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.out_index     = out_idx_r;
  assign out_ch.foreground    = out_fg_r;
  assign out_ch.within_a      = out_w_r[0];
  assign out_ch.within_b      = out_w_r[1];
  assign out_ch.within_c      = out_w_r[2];
  assign out_ch.out_frame_end = out_fe_r;

endmodule

>>> design/average_background_subtraction_unit.sv
// Path: queue, then stage B, stage C and the output register.
// Throughput: one item per cycle while the output side does not stall; the
//   sum store read-modify-write is closed with a one-entry bypass, so
//   repeated pixels keep full rate.
// Reset: synchronous, active low. The sum store is then zeroed by a sweep of
//   all 131072 entries (one entry a cycle) during which in_ch.ready stays low.
module average_background_subtraction_unit import abgs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  abgs_in_if.sink               in_ch,
  abgs_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [SCALE_W-1:0] hi_scale_r, hi_scale_nxt;
  logic [SCALE_W-1:0] low_scale_r, low_scale_nxt;

  logic    q_push, q_pop, clr_busy;
  cmd_t    q_cmd, q_head;
  q_stat_t q_stat;

  always_comb begin
    hi_scale_nxt  = hi_scale_r;
    low_scale_nxt = low_scale_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_HI_SCALE:  hi_scale_nxt  = cfg_data;
        CFG_LOW_SCALE: low_scale_nxt = cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_scale_r  <= HI_SCALE_RST;
      low_scale_r <= LOW_SCALE_RST;
    end else begin
      hi_scale_r  <= hi_scale_nxt;
      low_scale_r <= low_scale_nxt;
    end
  end

  abgs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .clr_busy (clr_busy),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  abgs_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_cmd),
    .pop   (q_pop),
    .dout  (q_head),
    .stat  (q_stat)
  );

  abgs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .hi_scale  (hi_scale_r),
    .low_scale (low_scale_r),
    .q_head    (q_head),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .clr_busy  (clr_busy),
    .out_ch    (out_ch)
  );

endmodule

>>> design/abgs_checker.sv
module abgs_checker import abgs_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_opcode,
  input logic out_valid,
  input logic out_ready,
  input logic foreground,
  input logic within_a,
  input logic within_b,
  input logic within_c
);

  // classify items transferred in but not yet transferred out
  logic [3:0] pend_r;
  logic       cls_in, res_out;

  assign cls_in  = in_valid && in_ready && (in_opcode == OP_CLASSIFY);
  assign res_out = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 4'(cls_in) - 4'(res_out);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_fg_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> foreground == !(within_a || within_b || within_c))
    else $error("foreground disagrees with channel flags");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 4'd0)
    else $error("result without a pending classify item");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input taken before the sum store sweep");

endmodule

bind average_background_subtraction_unit abgs_checker u_abgs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_opcode  (in_ch.opcode),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .foreground (out_ch.foreground),
  .within_a   (out_ch.within_a),
  .within_b   (out_ch.within_b),
  .within_c   (out_ch.within_c)
);

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import abgs_pkg::*;

  localparam int POOL_N          = 12;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int REPORT_LIMIT    = 10;

  typedef logic [PIXEL_INDEX_BITS-1:0] pix_idx_t;
  typedef logic [SUM_W-1:0] sum_t;

  typedef struct packed {
    pix_idx_t index;
    logic     foreground;
    logic     within_a;
    logic     within_b;
    logic     within_c;
    logic     frame_end;
  } verdict_t;

  typedef struct packed {
    sum_t [NUM_CH-1:0] csum;
    sum_t [NUM_CH-1:0] dsum;
    pix_t              prev;
  } pixel_model_t;

  // Background model of the block plus the queue of classify verdicts in flight.
  class background_model;
    pixel_model_t                model[int unsigned];
    logic [FRAME_COUNT_BITS-1:0] frame_count;
    bit                          first_frame;
    logic [SCALE_W-1:0]          hi_scale;
    logic [SCALE_W-1:0]          low_scale;
    verdict_t                    verdict_q[$];
    int unsigned                 learns;
    int unsigned                 classifies;
    int unsigned                 checked;
    int unsigned                 errors;

    function new();
      frame_count = '0;
      first_frame = 1'b1;
      hi_scale    = HI_SCALE_RST;
      low_scale   = LOW_SCALE_RST;
      learns      = 0;
      classifies  = 0;
      checked     = 0;
      errors      = 0;
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    function pixel_model_t entry(int unsigned idx);
      pixel_model_t e;
      e = '0;
      if (model.exists(idx)) e = model[idx];
      return e;
    endfunction

    // Range scaled by the count: lo <= x*cnt < hi.
    function void bounds(input int unsigned idx, input int k,
                         output longint lo, output longint hi, output longint cnt);
      pixel_model_t e;
      longint       s;
      longint       d;
      e = entry(idx);
      if (frame_count == 0) begin
        s   = 0;
        d   = 0;
        cnt = 1;
      end else begin
        s   = longint'(e.csum[k]);
        d   = longint'(e.dsum[k]);
        cnt = longint'(frame_count);
      end
      lo = s - longint'(low_scale) * (d + cnt);
      hi = s + longint'(hi_scale) * (d + cnt);
    endfunction

    // Sample value close to one end of the range, for boundary hits.
    function chan_t boundary_value(int unsigned idx, int k, bit upper);
      longint lo;
      longint hi;
      longint cnt;
      longint x;
      bounds(idx, k, lo, hi, cnt);
      if (upper) x = hi / cnt;
      else x = (lo <= 0) ? 0 : (lo + cnt - 1) / cnt;
      x += longint'($urandom_range(0, 2)) - 1;
      if (x < 0) x = 0;
      if (x > 255) x = 255;
      return chan_t'(x);
    endfunction

    function void take_pixel(logic op, pix_idx_t idx, pix_t px, logic fe);
      pixel_model_t e;
      verdict_t     v;
      bit           w[NUM_CH];
      longint       lo;
      longint       hi;
      longint       cnt;
      longint       xn;
      chan_t        ad;
      if (op == OP_LEARN) begin
        learns++;
        if (first_frame) begin
          e      = entry(idx);
          e.prev = px;
          model[idx] = e;
          if (fe) first_frame = 1'b0;
        end else if (frame_count != COUNT_MAX) begin
          e = entry(idx);
          for (int k = 0; k < NUM_CH; k++) begin
            ad = (px[k] > e.prev[k]) ? px[k] - e.prev[k] : e.prev[k] - px[k];
            e.csum[k] += sum_t'(px[k]);
            e.dsum[k] += sum_t'(ad);
          end
          e.prev = px;
          model[idx] = e;
          if (fe) frame_count++;
        end
      end else begin
        classifies++;
        for (int k = 0; k < NUM_CH; k++) begin
          bounds(idx, k, lo, hi, cnt);
          xn   = longint'(px[k]) * cnt;
          w[k] = (lo <= xn) && (xn < hi);
        end
        v.index      = idx;
        v.foreground = !w[0] && !w[1] && !w[2];
        v.within_a   = w[0];
        v.within_b   = w[1];
        v.within_c   = w[2];
        v.frame_end  = fe;
        verdict_q.push_back(v);
      end
    endfunction

    function bit count_error();
      errors++;
      return errors <= REPORT_LIMIT;
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      if (verdict_q.size() == 0) begin
        if (count_error())
          $display("[%0t] ERROR: result with nothing expected: idx %0d fg %b w %b%b%b fe %b",
                   $realtime, got.index, got.foreground, got.within_a, got.within_b,
                   got.within_c, got.frame_end);
        return;
      end
      want = verdict_q.pop_front();
      checked++;
      if (got.index !== want.index || got.foreground !== want.foreground ||
          got.within_a !== want.within_a || got.within_b !== want.within_b ||
          got.within_c !== want.within_c || got.frame_end !== want.frame_end) begin
        if (count_error())
          $display("[%0t] ERROR: idx %0d/%0d fg %b/%b w_a %b/%b w_b %b/%b w_c %b/%b fe %b/%b %s",
                   $realtime, want.index, got.index, want.foreground, got.foreground,
                   want.within_a, got.within_a, want.within_b, got.within_b,
                   want.within_c, got.within_c, want.frame_end, got.frame_end,
                   "(expected/actual)");
      end
    endfunction

    function void drop_leftovers();
      if (count_error())
        $display("[%0t] ERROR: %0d classify results never arrived", $realtime,
                 verdict_q.size());
      verdict_q.delete();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  abgs_in_if  in_ch ();
  abgs_out_if out_ch ();

  average_background_subtraction_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  background_model sb;
  pix_idx_t        pool_idx[POOL_N];
  pix_t            pool_base[POOL_N];
  int              send_idle_pct;
  int              recv_idle_pct;
  bit              hold_off_req;
  int              n_settings;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #8_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_verdict(verdict_t'({out_ch.out_index, out_ch.foreground, out_ch.within_a,
                                   out_ch.within_b, out_ch.within_c, out_ch.out_frame_end}));
  end

  function automatic chan_t near(chan_t base, int spread);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return chan_t'(v);
  endfunction

  function automatic pix_t noisy_pixel(int p);
    pix_t px;
    int   spread;
    case ($urandom_range(0, 2))
      0: spread = 2;
      1: spread = 10;
      default: spread = 60;
    endcase
    if ($urandom_range(0, 9) == 0) return pix_t'($urandom);
    for (int k = 0; k < NUM_CH; k++) px[k] = near(pool_base[p][k], spread);
    return px;
  endfunction

  function automatic pix_t edge_pixel(pix_idx_t idx);
    pix_t px;
    for (int k = 0; k < NUM_CH; k++) px[k] = sb.boundary_value(idx, k, $urandom_range(0, 1));
    return px;
  endfunction

  // Offer one item from a falling edge and return at the falling edge after its transfer.
  task automatic send_pixel(logic op, pix_idx_t idx, pix_t px, logic fe);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.pixel_index <= idx;
    in_ch.chan_a      <= px[0];
    in_ch.chan_b      <= px[1];
    in_ch.chan_c      <= px[2];
    in_ch.frame_end   <= fe;
    do @(posedge clk); while (!in_ch.ready);
    sb.take_pixel(op, idx, px, fe);
    @(negedge clk);
  endtask

  task automatic wait_quiet();
    int guard;
    in_ch.valid <= 1'b0;
    guard = 0;
    @(negedge clk);
    while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    if (sb.pending() != 0) sb.drop_leftovers();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_scales(logic [SCALE_W-1:0] hi, logic [SCALE_W-1:0] lo);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_HI_SCALE;
    cfg_data <= hi;
    @(negedge clk);
    cfg_idx  <= CFG_LOW_SCALE;
    cfg_data <= lo;
    @(negedge clk);
    cfg_we   <= 1'b0;
    sb.hi_scale  = hi;
    sb.low_scale = lo;
    n_settings++;
  endtask

  task automatic run_directed();
    // count zero in the first frame: a channel is within only when x < hi_scale
    send_pixel(OP_CLASSIFY, pool_idx[0], {8'd7, 8'd6, 8'd0}, 1'b0);
    // frame end on a classify is only echoed, the first frame goes on
    send_pixel(OP_CLASSIFY, pool_idx[1], '1, 1'b1);
    for (int p = 0; p < POOL_N; p++)
      send_pixel(OP_LEARN, pool_idx[p], pool_base[p], p == POOL_N - 1);
    // sums move while the count is still zero; the count-zero range still applies
    send_pixel(OP_LEARN, pool_idx[0], {8'd128, 8'd0, 8'd255}, 1'b0);
    send_pixel(OP_CLASSIFY, pool_idx[0], {8'd200, 8'd7, 8'd5}, 1'b0);
    send_pixel(OP_LEARN, pool_idx[1], {8'd1, 8'd255, 8'd0}, 1'b1);
    send_pixel(OP_CLASSIFY, pool_idx[0], {8'd128, 8'd0, 8'd255}, 1'b0);
    send_pixel(OP_CLASSIFY, pool_idx[1], edge_pixel(pool_idx[1]), 1'b0);
    // same pixel back to back through the sum store
    send_pixel(OP_LEARN, pool_idx[0], {8'd128, 8'd0, 8'd255}, 1'b1);
    send_pixel(OP_LEARN, pool_idx[0], '0, 1'b0);
    send_pixel(OP_CLASSIFY, pool_idx[0], '0, 1'b1);
    send_pixel(OP_CLASSIFY, pool_idx[0], edge_pixel(pool_idx[0]), 1'b0);
  endtask

  // Frames of learns over the pixel pool with classifies mixed in.
  task automatic run_random(int n_items);
    int       done;
    int       frame_len;
    int       p;
    int       last_p;
    pix_idx_t idx;
    pix_t     px;
    logic     fe;
    done   = 0;
    last_p = 0;
    while (done < n_items) begin
      frame_len = $urandom_range(1, 10);
      for (int i = 0; i < frame_len; i++) begin
        p      = ($urandom_range(0, 4) == 0) ? last_p : $urandom_range(0, POOL_N - 1);
        last_p = p;
        idx    = pool_idx[p];
        if ($urandom_range(0, 99) < 45) begin
          if ($urandom_range(0, 6) == 0) idx = pix_idx_t'($urandom_range(0, DEPTH - 1));
          for (int k = 0; k < NUM_CH; k++) begin
            case ($urandom_range(0, 3))
              0: px[k] = sb.boundary_value(idx, k, 1'b1);
              1: px[k] = sb.boundary_value(idx, k, 1'b0);
              2: px[k] = near(pool_base[p][k], 20);
              default: px[k] = chan_t'($urandom_range(0, 255));
            endcase
          end
          send_pixel(OP_CLASSIFY, idx, px, $urandom_range(0, 9) == 0);
        end else begin
          fe = (i == frame_len - 1) || ($urandom_range(0, 49) == 0);
          send_pixel(OP_LEARN, idx, noisy_pixel(p), fe);
        end
        done++;
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.opcode      <= OP_LEARN;
    in_ch.pixel_index <= '0;
    in_ch.chan_a      <= '0;
    in_ch.chan_b      <= '0;
    in_ch.chan_c      <= '0;
    in_ch.frame_end   <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= CFG_HI_SCALE;
    cfg_data          <= '0;
    hold_off_req  = 1'b0;
    n_settings    = 1;
    send_idle_pct = 33;
    recv_idle_pct = 77;

    pool_idx[0]  = '0;
    pool_idx[1]  = '1;
    pool_idx[2]  = pix_idx_t'(1 << (PIXEL_INDEX_BITS - 1));
    pool_idx[3]  = pix_idx_t'(17'h15555);
    pool_idx[4]  = pix_idx_t'(17'h0AAAA);
    pool_base[0] = '0;
    pool_base[1] = '1;
    for (int p = 2; p < POOL_N; p++) pool_base[p] = pix_t'($urandom);
    for (int p = 5; p < POOL_N; p++) pool_idx[p] = pix_idx_t'($urandom_range(0, DEPTH - 1));

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    wait_quiet();
    write_scales(4'd15, 4'd15);
    run_random(140);
    // long result-side hold-off while classifies keep coming, so the block backs up
    hold_off_req = 1'b1;
    for (int i = 0; i < 16; i++)
      send_pixel(OP_CLASSIFY, pool_idx[i % POOL_N], edge_pixel(pool_idx[i % POOL_N]), 1'b0);
    run_random(130);

    wait_quiet();
    send_idle_pct = 77;
    recv_idle_pct = 33;
    write_scales(4'd0, 4'd0);
    run_random(140);
    wait_quiet();
    write_scales(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    run_random(140);

    wait_quiet();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_scales(4'($urandom_range(1, 14)), 4'($urandom_range(1, 14)));
    run_random(150);
    wait_quiet();
    write_scales(4'd15, 4'd0);
    run_random(100);
    wait_quiet();
    write_scales(4'd0, 4'd15);
    for (int p = 0; p < POOL_N; p++)
      send_pixel(OP_CLASSIFY, pool_idx[p], edge_pixel(pool_idx[p]), 1'b0);
    wait_quiet();

    $display("Run covered %0d learn and %0d classify transfers, %0d results checked.",
             sb.learns, sb.classifies, sb.checked);
    $display("Frame count reached %0d of %0d over %0d scale settings, %0d pixels modeled.",
             sb.frame_count, COUNT_MAX, n_settings, sb.model.num());
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
